// File: src/amcp_pkg.sv
// ----------------------------------------------------------------------------
// amcp_pkg
// Shared constants and the result record of the ASCII motor command parser.
// ----------------------------------------------------------------------------
package amcp_pkg;

	localparam int TOKEN_CHARS_DEF = 7;
	localparam int QUEUE_DEPTH     = 2;

	localparam int DUTY_W  = 18;
	localparam int LED_W   = 21;
	localparam int FRAME_W = 9;
	localparam int RES_W   = 4 * DUTY_W + LED_W + FRAME_W + 5;
	localparam int DATA_W  = ((RES_W + 7) / 8) * 8;

	// Byte codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_C     = 8'h63;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_Z     = 8'h7A;

	// Motor duty slots: {side, direction}
	localparam logic [1:0] DUTY_LF = 2'd0;
	localparam logic [1:0] DUTY_LB = 2'd1;
	localparam logic [1:0] DUTY_RF = 2'd2;
	localparam logic [1:0] DUTY_RB = 2'd3;

	// One result word, last field in the lowest bits
	typedef struct packed {
		logic                       token_overflow;
		logic                       invalid_seen;
		logic                       disconnect;
		logic                       buzzer_on;
		logic signed [FRAME_W-1:0]  frame_size;
		logic                       camera_on;
		logic signed [LED_W-1:0]    front_led;
		logic signed [DUTY_W-1:0]   right_backward;
		logic signed [DUTY_W-1:0]   right_forward;
		logic signed [DUTY_W-1:0]   left_backward;
		logic signed [DUTY_W-1:0]   left_forward;
	} amcp_result_t;

endpackage

// File: src/amcp_front.sv
// ----------------------------------------------------------------------------
// amcp_front
// Collects message bytes into a token and hands each finished token on.
// ----------------------------------------------------------------------------
module amcp_front #(
	parameter int TOKEN_CHARS = amcp_pkg::TOKEN_CHARS_DEF,
	localparam int LW = $clog2(TOKEN_CHARS + 1),
	localparam int IW = $clog2(TOKEN_CHARS),
	localparam int EW = TOKEN_CHARS * 8 + LW + 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [7:0]    s_tdata,
	input  logic          q_full,
	output logic          q_push,
	output logic [EW-1:0] q_data
);
	import amcp_pkg::*;

	logic [7:0]                 chars_q [TOKEN_CHARS];
	logic [LW-1:0]              len_q;
	logic                       ovf_q;
	logic                       accept;
	logic                       is_end;
	logic                       has_room;
	logic [TOKEN_CHARS*8-1:0]   chars_flat;

	always_comb begin
		s_tready = !q_full;
		accept   = s_tvalid && s_tready;
		is_end   = (s_tdata == CH_NUL) || (s_tdata == CH_SPACE);
		has_room = (len_q < LW'(TOKEN_CHARS));
		q_push   = accept && is_end;
		for (int i = 0; i < TOKEN_CHARS; i++) begin
			chars_flat[i*8 +: 8] = chars_q[i];
		end
		q_data = {ovf_q, (s_tdata == CH_NUL), len_q, chars_flat};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (is_end) begin
				len_q <= '0;
				ovf_q <= 1'b0;
			end else if (has_room) begin
				len_q <= len_q + LW'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Token bytes: payload, no reset
	always_ff @(posedge clk) begin
		if (accept && !is_end && has_room) begin
			chars_q[len_q[IW-1:0]] <= s_tdata;
		end
	end

endmodule

// File: src/amcp_queue.sv
// ----------------------------------------------------------------------------
// amcp_queue
// Short token queue between the byte collector and the scanner.
// ----------------------------------------------------------------------------
module amcp_queue #(
	parameter int W = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic         valid,
	output logic [W-1:0] rdata
);
	import amcp_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;

	always_comb begin
		full  = (cnt_q == CW'(QUEUE_DEPTH));
		valid = (cnt_q != '0);
		rdata = mem_q[rd_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

// File: src/amcp_back.sv
// ----------------------------------------------------------------------------
// amcp_back
// Scans queued tokens, keeps the message fields and registers the result.
// ----------------------------------------------------------------------------
module amcp_back #(
	parameter int TOKEN_CHARS = amcp_pkg::TOKEN_CHARS_DEF,
	localparam int LW = $clog2(TOKEN_CHARS + 1),
	localparam int WW = TOKEN_CHARS * 8,
	localparam int EW = WW + LW + 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	input  logic [EW-1:0]          q_data,
	output logic                   q_pop,
	output logic                   res_valid,
	input  logic                   res_ready,
	output amcp_pkg::amcp_result_t res
);
	import amcp_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_NUM  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]        state_q;
	logic [WW-1:0]     win_q;
	logic [LW-1:0]     rem_q;
	logic              last_q;
	logic [WW-1:0]     nbuf_q;
	logic [LW-1:0]     nrem_q;
	logic [LED_W-1:0]  acc_q;
	logic              tgt_led_q;
	logic [1:0]        tgt_idx_q;

	logic [DUTY_W-1:0]  duty_q [4];
	logic [LED_W-1:0]   led_q;
	logic [FRAME_W-1:0] frame_q;
	logic               cam_q;
	logic               buz_q;
	logic               disc_q;
	logic               inv_q;
	logic               ovf_q;
	amcp_result_t       res_q;
	logic               res_valid_q;

	// Scan decode
	logic [7:0]       c;
	logic [7:0]       b1;
	logic [7:0]       b2;
	logic             side;
	logic             is_dig;
	logic [1:0]       sh;
	logic [1:0]       ns;
	logic             num_go;
	logic             tgt_led;
	logic [1:0]       tgt_idx;
	logic             zero_fwd;
	logic             zero_bwd;
	logic             set_cam;
	logic             clr_cam;
	logic             set_buz;
	logic             clr_buz;
	logic             set_disc;
	logic             set_inv;
	logic             set_frame;
	logic [WW-1:0]    win_next;
	logic [LW-1:0]    rem_next;
	logic [WW-1:0]    nbuf_next;
	logic [LW-1:0]    nrem_next;
	logic [7:0]       nb;
	logic [LED_W-1:0] digit;
	logic [LED_W-1:0] acc_next;
	logic             res_load;
	logic             pop_now;

	always_comb begin
		c      = win_q[7:0];
		b1     = (rem_q > LW'(1)) ? win_q[15:8] : CH_NUL;
		b2     = (rem_q > LW'(2)) ? win_q[23:16] : CH_NUL;
		side   = (c == CH_R);
		is_dig = c inside {[CH_0:CH_9]};

		sh        = 2'd1;
		ns        = 2'd1;
		num_go    = 1'b0;
		tgt_led   = 1'b0;
		tgt_idx   = DUTY_LF;
		zero_fwd  = 1'b0;
		zero_bwd  = 1'b0;
		set_cam   = 1'b0;
		clr_cam   = 1'b0;
		set_buz   = 1'b0;
		clr_buz   = 1'b0;
		set_disc  = 1'b0;
		set_inv   = 1'b0;
		set_frame = 1'b0;

		case (c)
			CH_L, CH_R: begin
				sh = 2'd2;
				if (b1 == CH_F) begin
					num_go   = 1'b1;
					ns       = 2'd2;
					sh       = 2'd3;
					tgt_idx  = {side, 1'b0};
					zero_bwd = 1'b1;
				end else if (b1 == CH_B) begin
					num_go   = 1'b1;
					ns       = 2'd2;
					sh       = 2'd3;
					tgt_idx  = {side, 1'b1};
					zero_fwd = 1'b1;
				end else if (b1 == CH_D) begin
					zero_fwd = 1'b1;
					zero_bwd = 1'b1;
				end
			end
			CH_G: begin
				num_go  = 1'b1;
				ns      = 2'd1;
				sh      = 2'd2;
				tgt_led = 1'b1;
			end
			CH_C: begin
				sh = 2'd2;
				if (b1 == CH_1) begin
					set_cam = 1'b1;
				end else if (b1 == CH_0) begin
					clr_cam = 1'b1;
				end
			end
			CH_S: begin
				sh        = 2'd2;
				set_frame = 1'b1;
			end
			CH_B: begin
				sh = 2'd2;
				if (b1 == CH_Z) begin
					sh = 2'd3;
					if (b2 == CH_1) begin
						set_buz = 1'b1;
					end else begin
						clr_buz = 1'b1;
					end
				end
			end
			CH_Z: begin
				set_disc = 1'b1;
			end
			default: begin
				set_inv = 1'b1;
			end
		endcase

		win_next  = win_q >> {sh, 3'b000};
		rem_next  = (rem_q > LW'(sh)) ? rem_q - LW'(sh) : '0;
		nbuf_next = win_q >> {ns, 3'b000};
		nrem_next = (rem_q > LW'(ns)) ? rem_q - LW'(ns) : '0;

		// Horner step, a non-digit counts as minus one
		nb       = nbuf_q[7:0];
		digit    = (nb inside {[CH_0:CH_9]}) ? LED_W'(nb - CH_0) : '1;
		acc_next = (acc_q << 3) + (acc_q << 1) + digit;

		pop_now  = (state_q == ST_IDLE) && q_valid;
		res_load = (state_q == ST_DONE) && (!res_valid_q || res_ready);

		q_pop     = pop_now;
		res_valid = res_valid_q;
		res       = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			nrem_q      <= '0;
			last_q      <= 1'b0;
			for (int i = 0; i < 4; i++) begin
				duty_q[i] <= '0;
			end
			led_q       <= '0;
			frame_q     <= '0;
			cam_q       <= 1'b0;
			buz_q       <= 1'b0;
			disc_q      <= 1'b0;
			inv_q       <= 1'b0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res_ready && !res_load) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop_now) begin
						rem_q   <= q_data[WW +: LW];
						last_q  <= q_data[WW + LW];
						ovf_q   <= ovf_q | q_data[WW + LW + 1];
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (rem_q == '0 || is_dig) begin
						rem_q   <= '0;
						state_q <= last_q ? ST_DONE : ST_IDLE;
					end else begin
						rem_q <= rem_next;
						if (zero_fwd) begin
							duty_q[{side, 1'b0}] <= '0;
						end
						if (zero_bwd) begin
							duty_q[{side, 1'b1}] <= '0;
						end
						if (set_cam) begin
							cam_q <= 1'b1;
						end
						if (clr_cam || set_disc) begin
							cam_q <= 1'b0;
						end
						if (set_buz) begin
							buz_q <= 1'b1;
						end
						if (clr_buz) begin
							buz_q <= 1'b0;
						end
						if (set_disc) begin
							disc_q <= 1'b1;
						end
						if (set_inv) begin
							inv_q <= 1'b1;
						end
						if (set_frame) begin
							frame_q <= {1'b0, b1} - FRAME_W'(CH_0);
						end
						if (num_go) begin
							nrem_q  <= nrem_next;
							state_q <= ST_NUM;
						end
					end
				end
				ST_NUM: begin
					if (nrem_q != '0) begin
						nrem_q <= nrem_q - LW'(1);
					end else begin
						if (tgt_led_q) begin
							led_q <= acc_q;
						end else begin
							duty_q[tgt_idx_q] <= acc_q[DUTY_W-1:0];
						end
						state_q <= ST_SCAN;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						res_valid_q <= 1'b1;
						for (int i = 0; i < 4; i++) begin
							duty_q[i] <= '0;
						end
						led_q   <= '0;
						frame_q <= '0;
						cam_q   <= 1'b0;
						buz_q   <= 1'b0;
						disc_q  <= 1'b0;
						inv_q   <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working buffers and result register: payload, no reset
	always_ff @(posedge clk) begin
		if (pop_now) begin
			win_q <= q_data[WW-1:0];
		end
		if (state_q == ST_SCAN && rem_q != '0 && !is_dig) begin
			win_q <= win_next;
			if (num_go) begin
				nbuf_q    <= nbuf_next;
				acc_q     <= '0;
				tgt_led_q <= tgt_led;
				tgt_idx_q <= tgt_idx;
			end
		end
		if (state_q == ST_NUM && nrem_q != '0) begin
			acc_q  <= acc_next;
			nbuf_q <= nbuf_q >> 8;
		end
		if (res_load) begin
			res_q.left_forward   <= duty_q[DUTY_LF];
			res_q.left_backward  <= duty_q[DUTY_LB];
			res_q.right_forward  <= duty_q[DUTY_RF];
			res_q.right_backward <= duty_q[DUTY_RB];
			res_q.front_led      <= led_q;
			res_q.camera_on      <= cam_q;
			res_q.frame_size     <= frame_q;
			res_q.buzzer_on      <= buz_q;
			res_q.disconnect     <= disc_q;
			res_q.invalid_seen   <= inv_q;
			res_q.token_overflow <= ovf_q;
		end
	end

endmodule

// File: src/ascii_motor_command_parser.sv
// ----------------------------------------------------------------------------
// ascii_motor_command_parser
// Parses a space-separated ASCII command line into motor, LED, camera,
// frame, buzzer and status fields; one result word per NUL-ended message.
// ----------------------------------------------------------------------------
//
//  channel  | dir | word                       | notes
//  ---------+-----+----------------------------+-------------------------------
//  s_*      | in  | s_tdata[7:0] = ch          | space ends a token, NUL a message
//  m_*      | out | m_tdata = result fields    | one word per message
//
// Cycles: the front takes one byte a cycle while the token queue has room.
//   The back pops a token, scans each command in it, accumulates the bytes
//   of a number and then closes the token; a message end adds a step that
//   loads the result register.
//   The back's scan loop sets the sustained rate.
// Reset: arst_n clears the token length, queue pointers, scan state, message
//   fields and the result valid; token bytes, buffers and the result register are not cleared.
// Stalls: a full queue drops s_tready; a held result word stalls only the
//   back at the next message end, and the front keeps collecting bytes
//   until the queue fills.
//
module ascii_motor_command_parser #(
	parameter int TOKEN_CHARS = amcp_pkg::TOKEN_CHARS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input stream
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] ch
	// Result stream
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// [17:0] left_forward, [35:18] left_backward, [53:36] right_forward,
	// [71:54] right_backward, [92:72] front_led, [93] camera_on,
	// [102:94] frame_size, [103] buzzer_on, [104] disconnect,
	// [105] invalid_seen, [106] token_overflow, [111:107] zero
	output logic [amcp_pkg::DATA_W-1:0] m_tdata
);
	import amcp_pkg::*;

	localparam int LW = $clog2(TOKEN_CHARS + 1);
	localparam int EW = TOKEN_CHARS * 8 + LW + 2;

	logic          q_push;
	logic          q_full;
	logic [EW-1:0] q_wdata;
	logic          q_pop;
	logic          q_valid;
	logic [EW-1:0] q_rdata;
	amcp_result_t  res;

	// Front: collect bytes, push a token at each space or NUL
	amcp_front #(
		.TOKEN_CHARS (TOKEN_CHARS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	// Token queue: lets the front run ahead of the scanner
	amcp_queue #(
		.W (EW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (q_rdata)
	);

	// Back: scan tokens, hold message fields, register the result word
	amcp_back #(
		.TOKEN_CHARS (TOKEN_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	// Pad the result record up to whole bytes
	assign m_tdata = {{(DATA_W - RES_W){1'b0}}, res};

`ifndef SYNTHESIS
	// The front never pushes into a full queue: s_tready must cover it
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("token pushed into a full queue");

	// The back only pops a token that is there
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("token popped from an empty queue");
`endif

endmodule
